// File: hdl/scmd_pkg.sv
// ----------------------------------------------------------------------------
// scmd_pkg
// Shared types, byte codes, command codes and the drive split function for
// the serial command motor drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scmd_pkg;

  // Frame delimiters
  localparam logic [7:0] START_BYTE = 8'h42;  // 'B'
  localparam logic [7:0] STOP_BYTE  = 8'h53;  // 'S'

  // Command codes
  localparam logic [7:0] CMD_SET_A    = 8'd1;
  localparam logic [7:0] CMD_SET_B    = 8'd2;
  localparam logic [7:0] CMD_GRIPPER  = 8'd3;
  localparam logic [7:0] CMD_BELT     = 8'd4;
  localparam logic [7:0] CMD_STOP_ALL = 8'd10;

  // Payload geometry: bytes beyond either limit are dropped
  localparam int PAYLOAD_BYTES = 4;
  localparam int WORD_BYTES    = 4;
  localparam int PAYLOAD_LIMIT = (PAYLOAD_BYTES < WORD_BYTES) ? PAYLOAD_BYTES : WORD_BYTES;

  // DAC and servo levels
  localparam logic [11:0]        DAC_MAX       = 12'd4095;
  localparam logic signed [31:0] DRIVE_LIMIT   = 32'sd4095;
  localparam logic [7:0]         GRIPPER_OPEN  = 8'd0;
  localparam logic [7:0]         GRIPPER_SHUT  = 8'd255;
  localparam logic [7:0]         BELT_IDLE     = 8'd90;
  localparam logic [7:0]         BELT_RUN      = 8'd255;

  // Frame parser phase; payload byte n sits in phase PH_BYTE0 + n
  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_COMMAND    = 3'd1,
    PH_BYTE0      = 3'd2,
    PH_BYTE1      = 3'd3,
    PH_BYTE2      = 3'd4,
    PH_BYTE3      = 3'd5,
    PH_BYTE4      = 3'd6,
    PH_OVERFLOW   = 3'd7
  } phase_t;

  // Actuator state after one beat has been parsed
  typedef struct packed {
    logic signed [31:0] drive_a;
    logic signed [31:0] drive_b;
    logic               gripper_closed;
    logic               belt_running;
    logic               done;
  } scmd_status_t;

  typedef struct packed {
    logic [11:0] fwd;
    logic [11:0] rev;
  } dac_pair_t;

  // Saturate a drive to +-4095 and split it into forward and reverse levels
  function automatic dac_pair_t split_drive(input logic signed [31:0] drive);
    dac_pair_t          pair;
    logic signed [31:0] neg;
    neg      = -drive;
    pair.fwd = '0;
    pair.rev = '0;
    if (drive > DRIVE_LIMIT) begin
      pair.fwd = DAC_MAX;
    end else if (drive < -DRIVE_LIMIT) begin
      pair.rev = DAC_MAX;
    end else if (drive > 32'sd0) begin
      pair.fwd = drive[11:0];
    end else begin
      pair.rev = neg[11:0];
    end
    return pair;
  endfunction

endpackage

// File: hdl/scmd_parser.sv
// ----------------------------------------------------------------------------
// scmd_parser
// Frame parser and actuator state. Decodes one byte per step and presents
// the actuator state that results from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scmd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx,
  output scmd_pkg::scmd_status_t status_next,
  output scmd_pkg::phase_t      phase
);

  scmd_pkg::phase_t   phase_next;
  logic [7:0]         command;
  logic [7:0]         command_next;
  logic [31:0]        payload;
  logic [31:0]        payload_next;
  logic signed [31:0] drive_a;
  logic signed [31:0] drive_b;
  logic               gripper_closed;
  logic               belt_running;
  logic [2:0]         byte_idx;
  logic               byte_take;

  // Payload byte index within the frame
  assign byte_idx  = 3'(phase) - 3'(scmd_pkg::PH_BYTE0);
  assign byte_take = {1'b0, byte_idx} < 4'(scmd_pkg::PAYLOAD_LIMIT);

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      scmd_pkg::PH_WAIT_START: begin
        if (rx == scmd_pkg::START_BYTE) phase_next = scmd_pkg::PH_COMMAND;
      end
      scmd_pkg::PH_COMMAND: begin
        phase_next = scmd_pkg::PH_BYTE0;
      end
      default: begin
        if (rx == scmd_pkg::STOP_BYTE) begin
          phase_next = scmd_pkg::PH_WAIT_START;
        end else if (phase != scmd_pkg::PH_OVERFLOW) begin
          phase_next = scmd_pkg::phase_t'(3'(phase) + 3'd1);
        end
      end
    endcase
  end

  // Command, payload and actuator updates
  always_comb begin
    command_next = command;
    payload_next = payload;
    status_next.drive_a        = drive_a;
    status_next.drive_b        = drive_b;
    status_next.gripper_closed = gripper_closed;
    status_next.belt_running   = belt_running;
    status_next.done           = 1'b0;
    unique case (phase)
      scmd_pkg::PH_WAIT_START: begin
      end
      scmd_pkg::PH_COMMAND: begin
        command_next = rx;
      end
      default: begin
        if (rx == scmd_pkg::STOP_BYTE) begin
          // close the frame and apply the command
          status_next.done = 1'b1;
          command_next     = '0;
          payload_next     = '0;
          case (command)
            scmd_pkg::CMD_STOP_ALL: begin
              status_next.drive_a = '0;
              status_next.drive_b = '0;
            end
            scmd_pkg::CMD_SET_A:   status_next.drive_a = payload;
            scmd_pkg::CMD_SET_B:   status_next.drive_b = payload;
            scmd_pkg::CMD_GRIPPER: status_next.gripper_closed = !gripper_closed;
            scmd_pkg::CMD_BELT:    status_next.belt_running = !belt_running;
            default: begin
            end
          endcase
        end else if (byte_take) begin
          // merge the byte into its little-endian lane
          payload_next[8*byte_idx[1:0] +: 8] = payload[8*byte_idx[1:0] +: 8] | rx;
        end
      end
    endcase
  end

  // Advance on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= scmd_pkg::PH_WAIT_START;
      command        <= '0;
      payload        <= '0;
      drive_a        <= '0;
      drive_b        <= '0;
      gripper_closed <= 1'b0;
      belt_running   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      command        <= command_next;
      payload        <= payload_next;
      drive_a        <= status_next.drive_a;
      drive_b        <= status_next.drive_b;
      gripper_closed <= status_next.gripper_closed;
      belt_running   <= status_next.belt_running;
    end
  end

endmodule

// File: hdl/scmd_dac_out.sv
// ----------------------------------------------------------------------------
// scmd_dac_out
// Result register. Splits both drives into DAC levels, maps the servo flags
// to positions and holds the beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scmd_dac_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  scmd_pkg::scmd_status_t status_next,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [11:0]            motor_a_forward,
  output logic [11:0]            motor_a_reverse,
  output logic [11:0]            motor_b_reverse,
  output logic [11:0]            motor_b_forward,
  output logic [7:0]             gripper_position,
  output logic [7:0]             belt_position,
  output logic                   frame_done
);

  scmd_pkg::dac_pair_t pair_a;
  scmd_pkg::dac_pair_t pair_b;

  // Saturate and split both drives
  assign pair_a = scmd_pkg::split_drive(status_next.drive_a);
  assign pair_b = scmd_pkg::split_drive(status_next.drive_b);

  // Hold valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      motor_a_forward  <= pair_a.fwd;
      motor_a_reverse  <= pair_a.rev;
      motor_b_reverse  <= pair_b.rev;
      motor_b_forward  <= pair_b.fwd;
      gripper_position <= status_next.gripper_closed ? scmd_pkg::GRIPPER_SHUT
                                                     : scmd_pkg::GRIPPER_OPEN;
      belt_position    <= status_next.belt_running ? scmd_pkg::BELT_RUN
                                                   : scmd_pkg::BELT_IDLE;
      frame_done       <= status_next.done;
    end
  end

endmodule

// File: hdl/serial_command_motor_drive.sv
// ----------------------------------------------------------------------------
// serial_command_motor_drive
// Serial command decoder for two motor drives, a gripper and a belt.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns one result beat per byte. A
// frame is 'B', a command byte, up to four little-endian payload bytes and a
// closing 'S'; further payload bytes are dropped. Each result gives the four
// DAC levels (drives saturated to +-4095), the two servo positions and a flag
// set on the byte that closed a frame. A byte is registered on input, then
// decoded and captured into the result register; one byte is accepted every
// cycle while results are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_command_motor_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] motor_a_forward,
  output logic [11:0] motor_a_reverse,
  output logic [11:0] motor_b_reverse,
  output logic [11:0] motor_b_forward,
  output logic [7:0]  gripper_position,
  output logic [7:0]  belt_position,
  output logic        frame_done
);

  logic                   in_valid_q;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   accept;
  scmd_pkg::scmd_status_t status_next;
  scmd_pkg::phase_t       phase;

  // Move the held byte on when the result register is free
  assign advance  = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= rx_byte;
    end
  end

  scmd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .rx          (in_byte),
    .status_next (status_next),
    .phase       (phase)
  );

  scmd_dac_out u_dac_out (
    .clk              (clk),
    .rst              (rst),
    .load             (advance),
    .status_next      (status_next),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .motor_a_forward  (motor_a_forward),
    .motor_a_reverse  (motor_a_reverse),
    .motor_b_reverse  (motor_b_reverse),
    .motor_b_forward  (motor_b_forward),
    .gripper_position (gripper_position),
    .belt_position    (belt_position),
    .frame_done       (frame_done)
  );

  // A closed frame leaves the parser waiting for the next start byte
  a_done_resets_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> phase == scmd_pkg::PH_WAIT_START)
    else $error("frame_done shown while parser is mid-frame");

  // A drive is never forward and reverse at once
  a_drive_a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_a_forward == '0 || motor_a_reverse == '0)
    else $error("motor A driven both ways");

  a_drive_b_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_b_forward == '0 || motor_b_reverse == '0)
    else $error("motor B driven both ways");

  // A beat that cannot advance into a stalled result register stays put
  a_stall_holds_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && out_valid && out_stall |=> in_valid_q && $stable(in_byte))
    else $error("held input beat lost under output stall");

endmodule
